// File: hdl/wsrq_pkg.sv
// shared types and constants for the work-stealing ready queues
// no dependencies
`default_nettype none
package wsrq_pkg;
    localparam int MaxWorkers = 16;
    localparam int MaxTasks   = 1024;
    localparam int WW         = $clog2(MaxWorkers);
    localparam int TW         = $clog2(MaxTasks);
    localparam int CW         = TW + 1;
    localparam logic [15:0] LfsrSeed = 16'hACE1;
    localparam logic [15:0] LfsrTaps = 16'hB400;

    // register byte addresses
    localparam logic [1:0] RegNumWorkers = 2'd0;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_TAKE   = 1'b1
    } cmd_t;

    // classified request passed from front to back
    typedef struct packed {
        logic          is_take;
        logic          balanced;
        logic [WW-1:0] worker;
        logic [TW-1:0] task_id;
        logic          at_head;
        logic          refused;
    } req_t;

    // one result beat
    typedef struct packed {
        logic          ok;
        logic [TW-1:0] task_out;
        logic [WW-1:0] worker_out;
        logic [CW-1:0] total_queued;
    } rsp_t;
endpackage
`default_nettype wire

// File: hdl/work_stealing_ready_queues_top.sv
// a refused item goes straight to the result; an insert to a named worker reads
// and writes the head/tail stores; a balanced insert first runs the remainder
// steps and picks the lighter candidate; a take first runs the steal search
// the back end takes one item at a time and works on it while
// the front end holds the next, and a stalled result holds the back end
// reset: synchronous active low; counts clear, lfsr to seed, 16 workers
`default_nettype none
module work_stealing_ready_queues_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [1:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_tvalid,
    output logic        s_tready,
    // cmd, worker, caller_is_worker, task_id, has_affinity, affinity_worker, at_head
    input  wire  [23:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // ok, task_out, worker_out, total_queued
    output logic [31:0] m_tdata
);
    localparam int WW = wsrq_pkg::WW;

    logic [4:0]        nw_reg;
    logic [WW:0]       n_eff;
    logic              q_valid, q_ready, m_valid;
    wsrq_pkg::req_t    q_req;
    wsrq_pkg::rsp_t    rsp;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nw_reg <= 5'd16;
        end else if (psel && penable && pwrite && paddr == wsrq_pkg::RegNumWorkers) begin
            nw_reg <= pwdata[4:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == wsrq_pkg::RegNumWorkers) ? {27'd0, nw_reg} : 32'd0;
    assign n_eff  = (nw_reg == 5'd0) ? (WW+1)'(1) :
                    (nw_reg > 5'(wsrq_pkg::MaxWorkers)) ?
                    (WW+1)'(wsrq_pkg::MaxWorkers) : nw_reg[WW:0];

    wsrq_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata[21:0]), .n_eff(n_eff), .q_valid(q_valid),
        .q_ready(q_ready), .q_req(q_req));

    wsrq_back u_back (
        .aclk(aclk), .aresetn(aresetn), .n_eff(n_eff), .q_valid(q_valid),
        .q_ready(q_ready), .q_req(q_req), .m_valid(m_valid), .m_ready(m_tready),
        .m_rsp(rsp));

    assign m_tvalid = m_valid;
    assign m_tdata  = {6'd0, rsp.total_queued, rsp.worker_out, rsp.task_out, rsp.ok};
endmodule
`default_nettype wire

// File: hdl/wsrq_ram.sv
// generic single-port write, single-port registered read ram
// no dependencies
`default_nettype none
module wsrq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire  [$clog2(Depth)-1:0] waddr,
    input  wire  [Width-1:0]         wdata,
    input  wire  [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hdl/wsrq_front.sv
// front end: accepts request beats, checks range, picks the target worker except for balanced inserts
// depends on wsrq_pkg
`default_nettype none
module wsrq_front (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [21:0]             s_tdata,
    input  wire  [wsrq_pkg::WW:0]   n_eff,
    output logic                    q_valid,
    input  wire                     q_ready,
    output wsrq_pkg::req_t          q_req
);
    // one-entry queue to the back end
    logic           full_reg, full_next;
    wsrq_pkg::req_t req_reg, req_next;

    logic [wsrq_pkg::WW-1:0] worker, aff, ch;
    logic                    is_take, is_wk, has_aff;
    wsrq_pkg::req_t          r;

    assign is_take = (s_tdata[0] == wsrq_pkg::CMD_TAKE);
    assign worker  = s_tdata[4:1];
    assign is_wk   = s_tdata[5];
    assign has_aff = s_tdata[16];
    assign aff     = s_tdata[20:17];
    assign ch      = has_aff ? aff : worker;

    // classify the beat
    always_comb begin
        r          = '0;
        r.is_take  = is_take;
        r.task_id  = s_tdata[15:6];
        r.at_head  = s_tdata[21];
        r.worker   = is_take ? worker : ch;
        r.balanced = !is_take && !has_aff && !is_wk;
        if (is_take || !r.balanced) begin
            r.refused = ({1'b0, r.worker} >= n_eff);
        end
    end

    assign s_tready = !full_reg || q_ready;
    assign q_valid  = full_reg;
    assign q_req    = req_reg;

    always_comb begin
        full_next = full_reg;
        req_next  = req_reg;
        if (q_ready) begin
            full_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            full_next = 1'b1;
            req_next  = r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
        req_reg <= req_next;
    end
endmodule
`default_nettype wire

// File: hdl/wsrq_back.sv
// back end: list updates over link/head/tail stores, counts, steal search
// depends on wsrq_pkg and wsrq_ram
`default_nettype none
module wsrq_back (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire  [wsrq_pkg::WW:0]   n_eff,
    input  wire                     q_valid,
    output logic                    q_ready,
    input  wire  wsrq_pkg::req_t    q_req,
    output logic                    m_valid,
    input  wire                     m_ready,
    output wsrq_pkg::rsp_t          m_rsp
);
    localparam int WW = wsrq_pkg::WW;
    localparam int TW = wsrq_pkg::TW;
    localparam int CW = wsrq_pkg::CW;
    localparam int NW = wsrq_pkg::MaxWorkers;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MOD, ST_PICK, ST_SEARCH, ST_READ, ST_WRITE, ST_OUT
    } state_t;

    state_t         state_reg, state_next;
    wsrq_pkg::req_t req_reg, req_next;
    logic [CW-1:0]  qcnt_reg [NW];
    logic [CW-1:0]  qcnt_next [NW];
    logic [CW-1:0]  total_reg, total_next;
    logic [15:0]    lfsr_reg, lfsr_next;
    logic [WW-1:0]  ra_reg, ra_next, rb_reg, rb_next, probe_reg, probe_next;
    logic [15:0]    xa_reg, xa_next, xb_reg, xb_next;
    logic [1:0]     mcnt_reg, mcnt_next;
    logic [WW:0]    steps_reg, steps_next;
    logic [TW-1:0]  head_val_reg, head_val_next;
    logic [TW-1:0]  tail_val_reg, tail_val_next;
    wsrq_pkg::rsp_t rsp_reg, rsp_next;
    wsrq_pkg::rsp_t out_reg, out_next;
    logic           mv_reg, mv_next;

    // ram ports
    logic          lk_we, hd_we, tl_we;
    logic [TW-1:0] lk_wa, lk_wd, lk_ra, lk_rd, hd_wd, hd_rd, tl_wd, tl_rd;
    logic [WW-1:0] hd_wa, hd_ra, tl_wa, tl_ra;

    wsrq_ram #(.Width(TW), .Depth(wsrq_pkg::MaxTasks)) u_link (
        .aclk(aclk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd),
        .raddr(lk_ra), .rdata(lk_rd));
    wsrq_ram #(.Width(TW), .Depth(NW)) u_head (
        .aclk(aclk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd),
        .raddr(hd_ra), .rdata(hd_rd));
    wsrq_ram #(.Width(TW), .Depth(NW)) u_tail (
        .aclk(aclk), .we(tl_we), .waddr(tl_wa), .wdata(tl_wd),
        .raddr(tl_ra), .rdata(tl_rd));

    logic [15:0]  lfsr_adv;
    logic [WW:0]  nxt_probe;
    logic [CW-1:0] cnt_probe;

    assign lfsr_adv = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ wsrq_pkg::LfsrTaps)
                                  : (lfsr_reg >> 1);
    assign nxt_probe = {1'b0, probe_reg} + 1'b1;
    assign cnt_probe = qcnt_reg[probe_reg];

    // four steps of remainder by n, partial remainder stays below n
    function automatic logic [WW-1:0] mod_step(input logic [WW-1:0] r_in,
                                               input logic [3:0] bits,
                                               input logic [WW:0] n);
        logic [WW:0] r;
        r = {1'b0, r_in};
        for (int i = 3; i >= 0; i--) begin
            r = {r[WW-1:0], bits[i]};
            if (r >= n) begin
                r = r - n;
            end
        end
        return r[WW-1:0];
    endfunction

    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;
    assign m_rsp   = out_reg;

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        qcnt_next     = qcnt_reg;
        total_next    = total_reg;
        lfsr_next     = lfsr_reg;
        ra_next       = ra_reg;
        rb_next       = rb_reg;
        xa_next       = xa_reg;
        xb_next       = xb_reg;
        mcnt_next     = mcnt_reg;
        probe_next    = probe_reg;
        steps_next    = steps_reg;
        head_val_next = head_val_reg;
        tail_val_next = tail_val_reg;
        rsp_next      = rsp_reg;
        out_next      = out_reg;
        mv_next       = mv_reg;
        lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = head_val_reg;
        hd_we = 1'b0; hd_wa = req_reg.worker; hd_wd = '0;
        tl_we = 1'b0; tl_wa = req_reg.worker; tl_wd = '0;
        hd_ra = probe_reg; tl_ra = req_reg.worker;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    req_next   = q_req;
                    probe_next = q_req.worker;
                    steps_next = '0;
                    rsp_next   = '0;
                    if (q_req.refused ||
                        (!q_req.is_take && total_reg >= CW'(wsrq_pkg::MaxTasks))) begin
                        state_next = ST_OUT;
                    end else if (q_req.is_take) begin
                        state_next = ST_SEARCH;
                    end else if (q_req.balanced) begin
                        lfsr_next  = lfsr_adv;
                        xa_next    = {6'd0, q_req.task_id};
                        xb_next    = lfsr_adv;
                        ra_next    = '0;
                        rb_next    = '0;
                        mcnt_next  = '0;
                        state_next = ST_MOD;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_MOD: begin
                // four remainder bits per cycle for both candidates
                ra_next   = mod_step(ra_reg, xa_reg[15:12], n_eff);
                rb_next   = mod_step(rb_reg, xb_reg[15:12], n_eff);
                xa_next   = {xa_reg[11:0], 4'd0};
                xb_next   = {xb_reg[11:0], 4'd0};
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 2'd3) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                // compare candidate loads, tie to the task-id candidate
                if (qcnt_reg[ra_reg] <= qcnt_reg[rb_reg]) begin
                    req_next.worker = ra_reg;
                end else begin
                    req_next.worker = rb_reg;
                end
                probe_next = req_next.worker;
                state_next = ST_READ;
            end
            ST_SEARCH: begin
                // one probe per cycle in rotating order
                if (steps_reg >= n_eff) begin
                    state_next = ST_OUT;
                end else if (cnt_probe != '0) begin
                    req_next.worker = probe_reg;
                    state_next      = ST_READ;
                end else begin
                    probe_next = (nxt_probe >= n_eff) ? '0 : nxt_probe[WW-1:0];
                    steps_next = steps_reg + 1'b1;
                end
            end
            ST_READ: begin
                // head/tail read issued here at probe/worker; ST_WRITE uses the data
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                head_val_next = hd_rd;
                tail_val_next = tl_rd;
                if (req_reg.is_take) begin
                    lk_ra      = hd_rd;
                    state_next = ST_OUT;
                    rsp_next.ok         = 1'b1;
                    rsp_next.task_out   = hd_rd;
                    rsp_next.worker_out = req_reg.worker;
                    qcnt_next[req_reg.worker] = qcnt_reg[req_reg.worker] - 1'b1;
                    total_next = total_reg - 1'b1;
                end else begin
                    lk_we = 1'b1;
                    lk_wa = req_reg.task_id;
                    if (qcnt_reg[req_reg.worker] == '0) begin
                        hd_we = 1'b1; hd_wd = req_reg.task_id;
                        tl_we = 1'b1; tl_wd = req_reg.task_id;
                    end else if (req_reg.at_head) begin
                        lk_wd = hd_rd;
                        hd_we = 1'b1; hd_wd = req_reg.task_id;
                    end else begin
                        tl_we = 1'b1; tl_wd = req_reg.task_id;
                    end
                    qcnt_next[req_reg.worker] = qcnt_reg[req_reg.worker] + 1'b1;
                    total_next = total_reg + 1'b1;
                    rsp_next.ok         = 1'b1;
                    rsp_next.worker_out = req_reg.worker;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // finish second write of the item, then post the result
                if (req_reg.is_take && rsp_reg.ok) begin
                    hd_we = 1'b1; hd_wd = lk_rd;
                end else if (!req_reg.is_take && rsp_reg.ok && !req_reg.at_head &&
                             qcnt_reg[req_reg.worker] != CW'(1)) begin
                    lk_we = 1'b1; lk_wa = tail_val_reg; lk_wd = req_reg.task_id;
                end
                if (!mv_reg || m_ready) begin
                    out_next              = rsp_reg;
                    out_next.total_queued = total_reg;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < NW; i++) qcnt_reg[i] <= '0;
            total_reg <= '0;
            lfsr_reg  <= wsrq_pkg::LfsrSeed;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            qcnt_reg  <= qcnt_next;
            total_reg <= total_next;
            lfsr_reg  <= lfsr_next;
            mv_reg    <= mv_next;
        end
        req_reg      <= req_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        xa_reg       <= xa_next;
        xb_reg       <= xb_next;
        mcnt_reg     <= mcnt_next;
        probe_reg    <= probe_next;
        steps_reg    <= steps_next;
        head_val_reg <= head_val_next;
        tail_val_reg <= tail_val_next;
        rsp_reg      <= rsp_next;
        out_reg      <= out_next;
    end
endmodule
`default_nettype wire

// File: hdl/wsrq_checker.sv
// port-level checks for the ready queue block
// depends on work_stealing_ready_queues_top ports
`default_nettype none
module wsrq_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire        pready
);
    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("beat changed");
    // refused results carry no task or worker
    a_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[14:1] == 14'd0) else $error("refused payload");
    // total never exceeds the task store
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[25:15] <= 11'd1024) else $error("total overflow");
    a_pready: assert property (@(posedge aclk) pready) else $error("pready low");
endmodule

bind work_stealing_ready_queues_top wsrq_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .pready(pready));
`default_nettype wire

// File: test/work_stealing_ready_queues_top_test.sv
// testbench for the work-stealing ready queues: drives request beats, predicts
// each result beat from its own queue model and checks it field by field
// depends on wsrq_pkg and work_stealing_ready_queues_top
`default_nettype none
module work_stealing_ready_queues_top_test;

    typedef struct {
        wsrq_pkg::cmd_t cmd;
        logic [3:0]  worker;
        logic        from_worker;
        logic [9:0]  task_id;
        logic        pinned;
        logic [3:0]  pin_worker;
        logic        at_head;
    } request_t;

    typedef struct {
        logic        ok;
        logic [9:0]  task_out;
        logic [3:0]  worker_out;
        logic [10:0] total_queued;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // scheduler state as predicted
    logic [9:0]  link_of [wsrq_pkg::MaxTasks];
    logic [9:0]  head_of [wsrq_pkg::MaxWorkers];
    logic [9:0]  tail_of [wsrq_pkg::MaxWorkers];
    logic [10:0] depth_of [wsrq_pkg::MaxWorkers];
    logic [10:0] tasks_held;
    logic [15:0] lfsr;
    logic [4:0]  workers_reg;
    logic [wsrq_pkg::MaxTasks-1:0] is_queued;

    outcome_t    pending_outcomes[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;

    always #6 aclk = ~aclk;

    work_stealing_ready_queues_top u_top (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
    );

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic int active_workers();
        if (workers_reg == 0) return 1;
        if (workers_reg > wsrq_pkg::MaxWorkers) return wsrq_pkg::MaxWorkers;
        return workers_reg;
    endfunction

    // compute the outcome of one accepted request and update the queues
    function automatic outcome_t schedule_request(input request_t r);
        outcome_t o;
        int n, ra, rb, sel, probe;
        logic [9:0] t;
        o = '{1'b0, 10'd0, 4'd0, 11'd0};
        n = active_workers();
        if (r.cmd == wsrq_pkg::CMD_INSERT) begin
            if (tasks_held < wsrq_pkg::MaxTasks) begin
                if (r.pinned) sel = r.pin_worker;
                else if (r.from_worker) sel = r.worker;
                else begin
                    lfsr = lfsr[0] ? ((lfsr >> 1) ^ wsrq_pkg::LfsrTaps) : (lfsr >> 1);
                    ra = r.task_id % n;
                    rb = lfsr % n;
                    sel = (depth_of[ra] <= depth_of[rb]) ? ra : rb;
                end
                if (sel < n) begin
                    if (depth_of[sel] == 0) begin
                        link_of[r.task_id] = '0;
                        head_of[sel] = r.task_id;
                        tail_of[sel] = r.task_id;
                    end else if (r.at_head) begin
                        link_of[r.task_id] = head_of[sel];
                        head_of[sel] = r.task_id;
                    end else begin
                        link_of[r.task_id] = '0;
                        link_of[tail_of[sel]] = r.task_id;
                        tail_of[sel] = r.task_id;
                    end
                    depth_of[sel]++;
                    tasks_held++;
                    is_queued[r.task_id] = 1'b1;
                    o.ok = 1'b1;
                    o.worker_out = 4'(sel);
                end
            end
        end else if (r.worker < n) begin
            // own queue first, then steal in rotating order
            for (int i = 0; i < n; i++) begin
                probe = (r.worker + i) % n;
                if (depth_of[probe] > 0) begin
                    t = head_of[probe];
                    head_of[probe] = link_of[t];
                    depth_of[probe]--;
                    tasks_held--;
                    is_queued[t] = 1'b0;
                    o.ok = 1'b1;
                    o.task_out = t;
                    o.worker_out = 4'(probe);
                    break;
                end
            end
        end
        o.total_queued = tasks_held;
        return o;
    endfunction

    // send one request beat, predict at acceptance, then maybe go idle
    task automatic send_request(input request_t r);
        s_tvalid <= 1'b1;
        s_tdata <= {2'b0, r.at_head, r.pin_worker, r.pinned, r.task_id,
                    r.from_worker, r.worker, r.cmd};
        do @(posedge aclk); while (!s_tready);
        pending_outcomes.push_back(schedule_request(r));
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_workers(input logic [4:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= wsrq_pkg::RegNumWorkers;
        pwdata <= {27'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        workers_reg = value;
    endtask

    function automatic request_t make_request(input wsrq_pkg::cmd_t c, input int w,
            input bit fw, input int t, input bit pin, input int pw, input bit hd);
        request_t r;
        r.cmd = c; r.worker = 4'(w); r.from_worker = fw; r.task_id = 10'(t);
        r.pinned = pin; r.pin_worker = 4'(pw); r.at_head = hd;
        return r;
    endfunction

    // random request, inserts use a task id that is not queued yet
    function automatic request_t random_request();
        request_t r;
        int tries;
        r.cmd = ($urandom_range(99) < (tasks_held > 600 ? 70 : 45)) ?
                wsrq_pkg::CMD_TAKE : wsrq_pkg::CMD_INSERT;
        r.worker = 4'($urandom_range(15));
        r.from_worker = 1'($urandom_range(1));
        r.pinned = ($urandom_range(99) < 30);
        r.pin_worker = 4'($urandom_range(15));
        r.at_head = 1'($urandom_range(1));
        r.task_id = 10'($urandom_range(1023));
        tries = 0;
        while (is_queued[r.task_id] && tries < 64) begin
            r.task_id = 10'($urandom_range(1023));
            tries++;
        end
        if (is_queued[r.task_id]) r.cmd = wsrq_pkg::CMD_TAKE;
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[0], 0);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_tdata[0] !== want.ok) report_mismatch("ok", m_tdata[0], want.ok);
                if (m_tdata[10:1] !== want.task_out)
                    report_mismatch("task_out", m_tdata[10:1], want.task_out);
                if (m_tdata[14:11] !== want.worker_out)
                    report_mismatch("worker_out", m_tdata[14:11], want.worker_out);
                if (m_tdata[25:15] !== want.total_queued)
                    report_mismatch("total_queued", m_tdata[25:15], want.total_queued);
            end
        end
    end

    // receiver readiness with random stalls and long hold-offs
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_directed();
        // explicit worker, affinity, head and tail, balanced placement, then takes and steals
        send_request(make_request(wsrq_pkg::CMD_TAKE, 0, 1, 0, 0, 0, 0));
        send_request(make_request(wsrq_pkg::CMD_INSERT, 3, 1, 0, 0, 0, 0));
        send_request(make_request(wsrq_pkg::CMD_INSERT, 3, 1, 1023, 0, 0, 0));
        send_request(make_request(wsrq_pkg::CMD_INSERT, 3, 1, 512, 0, 0, 1));
        send_request(make_request(wsrq_pkg::CMD_INSERT, 0, 0, 7, 1, 15, 0));
        send_request(make_request(wsrq_pkg::CMD_INSERT, 15, 0, 100, 0, 0, 0));
        send_request(make_request(wsrq_pkg::CMD_INSERT, 15, 0, 101, 0, 0, 1));
        send_request(make_request(wsrq_pkg::CMD_INSERT, 0, 0, 102, 0, 0, 0));
        send_request(make_request(wsrq_pkg::CMD_TAKE, 3, 0, 0, 0, 0, 0));
        send_request(make_request(wsrq_pkg::CMD_TAKE, 3, 1, 0, 0, 0, 0));
        send_request(make_request(wsrq_pkg::CMD_TAKE, 14, 1, 0, 0, 0, 0));
        for (int i = 0; i < 6; i++)
            send_request(make_request(wsrq_pkg::CMD_TAKE, 15, 1, 0, 0, 0, 0));
        wait_drained();
        // fewer workers: out-of-range worker and affinity are refused
        write_workers(5'd5);
        send_request(make_request(wsrq_pkg::CMD_INSERT, 7, 1, 20, 0, 0, 0));
        send_request(make_request(wsrq_pkg::CMD_INSERT, 0, 0, 21, 1, 9, 0));
        send_request(make_request(wsrq_pkg::CMD_INSERT, 4, 1, 22, 0, 0, 0));
        send_request(make_request(wsrq_pkg::CMD_TAKE, 5, 1, 0, 0, 0, 0));
        send_request(make_request(wsrq_pkg::CMD_TAKE, 0, 0, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_store_full();
        // fill every task id, one more insert is refused, then take part back
        write_workers(5'd16);
        for (int t = 0; t < wsrq_pkg::MaxTasks; t++)
            send_request(make_request(wsrq_pkg::CMD_INSERT, t % 16, t[0], t, t[1],
                                      t % 13, t[2]));
        send_request(make_request(wsrq_pkg::CMD_INSERT, 0, 0, 5, 0, 0, 0));
        for (int t = 0; t < 300; t++)
            send_request(make_request(wsrq_pkg::CMD_TAKE, $urandom_range(15), 0, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_random(input logic [4:0] workers, input int idle, input int stall,
            input int count);
        write_workers(workers);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++) send_request(random_request());
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_workers(5'd4);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_cycles = 400;
        for (int i = 0; i < 40; i++) send_request(random_request());
        // pause until everything is back
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        for (int i = 0; i < 40; i++) send_request(random_request());
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < wsrq_pkg::MaxTasks; i++) link_of[i] = '0;
        for (int i = 0; i < wsrq_pkg::MaxWorkers; i++) begin
            head_of[i] = '0; tail_of[i] = '0; depth_of[i] = '0;
        end
        tasks_held = '0;
        lfsr = wsrq_pkg::LfsrSeed;
        workers_reg = 5'd16;
        is_queued = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_directed();
        test_store_full();
        test_random(5'd16, 0, 0, 120);
        test_random(5'd1, 60, 0, 80);
        test_random(5'd0, 0, 60, 60);
        test_random(5'd31, 33, 33, 100);
        test_random(5'd7, 0, 0, 60);
        test_backpressure();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #(12 * 3000000);
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// File: work_stealing_ready_queues_top.f
hdl/wsrq_pkg.sv
hdl/wsrq_ram.sv
hdl/wsrq_front.sv
hdl/wsrq_back.sv
hdl/work_stealing_ready_queues_top.sv
hdl/wsrq_checker.sv
test/work_stealing_ready_queues_top_test.sv
